/* sv/spq_pkg.sv */
// spq_pkg: shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_EMPTY      = 2'd2
    } status_t;

    localparam logic ACT_INSERT     = 1'b0;
    localparam logic ACT_REMOVE     = 1'b1;
    localparam logic MODE_LOW_FIRST = 1'b0;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    // per-cell control from the top level
    typedef struct packed {
        cell_op_t op;
        logic     live;     // slot holds an entry
        logic     at_tail;  // first free slot
    } cell_ctrl_t;

endpackage

/* sv/sorted_priority_queue.sv */
// sorted_priority_queue: top level, bounded priority queue on a row of cells.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (in_valid/in_ready, action, value): one beat is one insert
//   or remove. Output channel (out_valid/out_ready, status, removed_value,
//   element_count, is_empty, is_full): one result beat per input beat, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_data): writes order_mode; always
//   ready. Write it only while the queue is idle.
// Storage is a chain of DEPTH cells kept in ascending order. An insert compares
// against every live cell at once and each cell from the insert point on takes its
// left neighbor or the new value; a lowest-first remove shifts the row left by one; a
// highest-first remove just drops the tail through the count.
// The result is registered and is valid in the cycle after the input beat is accepted.
// Throughput: one item per cycle while the receiver takes each result, set by the
// cell update and the one-deep output register.
// When the receiver stalls, the held result blocks in_ready until it is taken;
// the result is taken and the next item accepted in the same cycle.
// Reset empties the queue (count to zero), clears out_valid and sets
// order_mode to lowest-first. Cell contents are not cleared.
module sorted_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output spq_pkg::status_t   status,
    output logic signed [31:0] removed_value,
    output logic [3:0]         element_count,
    output logic               is_empty,
    output logic               is_full,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [CW-1:0]      count_reg, count_next;
    logic               mode_reg;
    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic signed [31:0] removed_reg, removed_next;
    logic [CW-1:0]      res_count_reg;

    logic               accept;
    logic               insert_ok, remove_ok;
    cell_op_t           op;
    logic [CW-1:0]      tail_pos;

    logic signed [31:0] cell_value [DEPTH];
    logic               cell_gt    [DEPTH];
    cell_ctrl_t         cell_ctrl  [DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign insert_ok = (action == ACT_INSERT) && (count_reg != DEPTH_C);
    assign remove_ok = (action == ACT_REMOVE) && (count_reg != '0);
    assign tail_pos  = count_reg - ONE_C;

    always_comb
    begin
        op = CELL_HOLD;
        if (accept && insert_ok)
        begin
            op = CELL_INSERT;
        end
        else if (accept && remove_ok && (mode_reg == MODE_LOW_FIRST))
        begin
            op = CELL_SHIFT;
        end
    end

    // cell row: slot 0 holds the lowest value
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_ctrl[gi].op      = op;
            assign cell_ctrl[gi].live    = CW'(gi) < count_reg;
            assign cell_ctrl[gi].at_tail = CW'(gi) == count_reg;
            if (gi == 0)
            begin : g_first
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (cell_ctrl[gi]),
                    .ins_value   (value),
                    .left_value  (value),
                    .left_gt     (1'b0),
                    .right_value (cell_value[(gi + 1) % DEPTH]),
                    .value       (cell_value[gi]),
                    .gt          (cell_gt[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_last
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (cell_ctrl[gi]),
                    .ins_value   (value),
                    .left_value  (cell_value[gi - 1]),
                    .left_gt     (cell_gt[gi - 1]),
                    .right_value (cell_value[gi]),
                    .value       (cell_value[gi]),
                    .gt          (cell_gt[gi])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk         (clk),
                    .ctrl        (cell_ctrl[gi]),
                    .ins_value   (value),
                    .left_value  (cell_value[gi - 1]),
                    .left_gt     (cell_gt[gi - 1]),
                    .right_value (cell_value[gi + 1]),
                    .value       (cell_value[gi]),
                    .gt          (cell_gt[gi])
                );
            end
        end
    endgenerate

    // result and new count
    always_comb
    begin
        count_next   = count_reg;
        status_next  = STATUS_DONE;
        removed_next = '0;
        if (action == ACT_INSERT)
        begin
            if (insert_ok)
            begin
                count_next = count_reg + ONE_C;
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
        else
        begin
            if (remove_ok)
            begin
                count_next   = tail_pos;
                removed_next = (mode_reg == MODE_LOW_FIRST) ? cell_value[0]
                                                            : cell_value[tail_pos[IW-1:0]];
            end
            else
            begin
                status_next = STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mode_reg      <= MODE_LOW_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            res_count_reg <= count_next;
        end
    end

    logic [CW+3:0] count_ext;
    assign count_ext     = {4'b0000, res_count_reg};

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign element_count = count_ext[3:0];
    assign is_empty      = (res_count_reg == '0);
    assign is_full       = (res_count_reg == DEPTH_C);

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && insert_ok) |=> (count_reg == $past(count_reg) + ONE_C))
        else $error("insert did not grow the count");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> (res_count_reg == count_reg))
        else $error("result count differs from held count");

    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !insert_ok && !remove_ok) |=> $stable(count_reg))
        else $error("refused item changed the count");

endmodule

/* sv/spq_cell.sv */
// spq_cell: one slot of the sorted chain, compare-and-shift storage cell.
// Depends on spq_pkg.
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic signed [31:0]  ins_value,
    input  logic signed [31:0]  left_value,
    input  logic                left_gt,
    input  logic signed [31:0]  right_value,
    output logic signed [31:0]  value,
    output logic                gt
);
    import spq_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // new value sorts before this entry
    assign gt    = ctrl.live && (ins_value < value_reg);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (gt || ctrl.at_tail)
                begin
                    value_next = left_gt ? left_value : ins_value;
                end
            end
            CELL_SHIFT:  value_next = right_value;
            default:     value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* tb/tb.sv */
// tb: self-checking bench for sorted_priority_queue with a shadow queue predictor.
// Depends on spq_pkg and sorted_priority_queue; drives random idles, stalls and a long hold.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 60;
    localparam logic MODE_HIGH_FIRST = ~MODE_LOW_FIRST;

    // one request waiting to go out, with the idle cycles that precede it
    typedef struct packed {
        logic               act;
        logic signed [31:0] val;
        logic [3:0]         gap;
    } request_t;

    // what one result beat should carry
    typedef struct packed {
        status_t            status;
        logic signed [31:0] removed;
        logic [3:0]         count;
        logic               empty;
        logic               full;
    } queue_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = ACT_INSERT;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    status_t            status;
    logic signed [31:0] removed_value;
    logic [3:0]         element_count;
    logic               is_empty;
    logic               is_full;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = MODE_LOW_FIRST;

    request_t           request_q[$];
    queue_result_t      awaited_results[$];

    // shadow copy of the queue contents, kept ascending
    logic signed [31:0] shadow_vals[DEPTH];
    int                 shadow_count = 0;
    logic               shadow_mode = MODE_LOW_FIRST;

    int  wait_left = -1;
    int  stall_left = 0;
    int  hold_left = 0;
    logic hold_go = 1'b0;
    logic rx_eager = 1'b0;
    bit  tx_eager = 1'b0;
    int  cycles = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  inserts = 0;
    int  removes = 0;
    int  refused_inserts = 0;
    int  refused_removes = 0;
    int  mode_writes = 0;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .removed_value(removed_value),
        .element_count(element_count),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one accepted request to the shadow queue and record its result.
    task automatic apply_request(input logic act, input logic signed [31:0] val);
        queue_result_t r;
        int pos;
        int i;
        r.status  = STATUS_DONE;
        r.removed = '0;
        if (act == ACT_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = STATUS_FULL;
                refused_inserts++;
            end
            else begin
                // walk down from the tail, moving larger entries up one slot
                pos = shadow_count;
                while (pos > 0 && val < shadow_vals[pos - 1]) begin
                    shadow_vals[pos] = shadow_vals[pos - 1];
                    pos--;
                end
                shadow_vals[pos] = val;
                shadow_count++;
                inserts++;
            end
        end
        else begin
            if (shadow_count == 0) begin
                r.status = STATUS_EMPTY;
                refused_removes++;
            end
            else if (shadow_mode == MODE_LOW_FIRST) begin
                r.removed = shadow_vals[0];
                for (i = 1; i < shadow_count; i++)
                    shadow_vals[i - 1] = shadow_vals[i];
                shadow_count--;
                removes++;
            end
            else begin
                r.removed = shadow_vals[shadow_count - 1];
                shadow_count--;
                removes++;
            end
        end
        r.count = 4'(shadow_count);
        r.empty = (shadow_count == 0);
        r.full  = (shadow_count == DEPTH);
        awaited_results.push_back(r);
    endtask

    // Input side: offers queued requests, predicts each one at acceptance.
    always @(posedge clk) begin : driver
        request_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            action   <= ACT_INSERT;
            value    <= '0;
        end
        else begin
            if (in_valid && in_ready)
                apply_request(action, value);
            if (!in_valid || in_ready) begin
                if (request_q.size() == 0) begin
                    in_valid <= 1'b0;
                end
                else begin
                    if (wait_left < 0)
                        wait_left = request_q[0].gap;
                    if (wait_left > 0) begin
                        wait_left--;
                        in_valid <= 1'b0;
                    end
                    else begin
                        nxt = request_q.pop_front();
                        wait_left = -1;
                        in_valid <= 1'b1;
                        action   <= nxt.act;
                        value    <= nxt.val;
                    end
                end
            end
        end
    end

    // Long receiver hold, counted here and started by the stimulus.
    always @(posedge clk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Output side: random stalls, checks each result beat against the oldest expectation.
    always @(posedge clk) begin : monitor
        queue_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat: status %0d removed %0d count %0d",
                                 status, removed_value, element_count);
                end
                else begin
                    want = awaited_results.pop_front();
                    if (status !== want.status || removed_value !== want.removed ||
                        element_count !== want.count || is_empty !== want.empty ||
                        is_full !== want.full) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: beat %0d expected status %0d removed %0d count %0d empty %b full %b",
                                     results_seen, want.status, want.removed, want.count,
                                     want.empty, want.full);
                            $display("       got      status %0d removed %0d count %0d empty %b full %b",
                                     status, removed_value, element_count, is_empty, is_full);
                        end
                    end
                end
                results_seen++;
                stall_left = rx_eager ? 0 : $urandom_range(0, 13);
            end
            else if (stall_left != 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results still awaited",
                     cycles, awaited_results.size());
            $display("sorted_priority_queue test failed");
            $finish;
        end
    end

    task automatic queue_request(input logic act, input logic signed [31:0] val);
        request_t r;
        r.act = act;
        r.val = val;
        r.gap = tx_eager ? 4'd0 : 4'($urandom_range(0, 13));
        request_q.push_back(r);
    endtask

    // mix of extremes, a narrow band for duplicates, and full-range words
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return int'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // sample at the falling edge so all edge updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || awaited_results.size() != 0);
    endtask

    task automatic set_order_mode(input logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_mode = mode;
        mode_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(input int n, input int insert_pct);
        int k;
        for (k = 0; k < n; k++)
            queue_request(($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE,
                          pick_value());
    endtask

    initial begin : stimulus
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_order_mode(MODE_LOW_FIRST);

        // Directed, lowest first: empty remove, extremes, duplicates, full refusal.
        queue_request(ACT_REMOVE, 32'sh7fff_ffff);
        queue_request(ACT_INSERT, 32'sh7fff_ffff);
        queue_request(ACT_INSERT, 32'sh8000_0000);
        queue_request(ACT_INSERT, 32'sd0);
        queue_request(ACT_INSERT, -32'sd1);
        queue_request(ACT_INSERT, 32'sd1);
        queue_request(ACT_INSERT, 32'sd5);
        queue_request(ACT_INSERT, 32'sd5);
        queue_request(ACT_INSERT, -32'sd7);
        queue_request(ACT_INSERT, 32'sd42);
        repeat (8) queue_request(ACT_REMOVE, 32'sd0);
        queue_request(ACT_REMOVE, 32'sh8000_0000);
        wait_idle();

        // Mode flip while entries are held: highest now leaves first.
        queue_request(ACT_INSERT, 32'sd3);
        queue_request(ACT_INSERT, 32'sd9);
        queue_request(ACT_INSERT, -32'sd2);
        wait_idle();
        set_order_mode(MODE_HIGH_FIRST);
        repeat (4) queue_request(ACT_REMOVE, 32'sd0);
        wait_idle();

        // Random phases; the queue is left as is across each mode write.
        for (ph = 0; ph < 6; ph++) begin
            tx_eager = (ph % 3 == 1);
            rx_eager <= (ph % 3 == 1);
            if (ph == 1) begin
                // receiver parks while the sender keeps going, so in_ready backs up
                tx_eager = 1'b1;
                random_burst(30, 60);
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
                wait_idle();
            end
            case (ph)
                0:       random_burst(250, 60);
                1:       random_burst(250, 40);
                2:       random_burst(250, 50);
                3:       random_burst(250, 70);
                4:       random_burst(250, 30);
                default: random_burst(250, 50);
            endcase
            wait_idle();
            @(posedge clk);
            set_order_mode((ph % 2 == 0) ? MODE_LOW_FIRST : MODE_HIGH_FIRST);
        end

        wait_idle();
        repeat (5) @(posedge clk);

        $display("Covered %0d result beats: %0d inserts, %0d removes, %0d full refusals,",
                 results_seen, inserts, removes, refused_inserts);
        $display("%0d empty refusals, %0d order-mode writes, %0d mismatches",
                 refused_removes, mode_writes, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("sorted_priority_queue test passed");
        else
            $display("sorted_priority_queue test failed");
        $finish;
    end

endmodule
